[rtl/smp_pkg.sv]
// Shared constants, types and arithmetic helpers for the skeleton matrix palette.
// No dependencies.
package smp_pkg;
   localparam int NODE_SLOTS_DEF = 256;
   localparam int FRAC_BITS_DEF = 16;
   localparam logic [7:0] ROOT_MARK = 8'hFF;
   localparam int QUAT_FRAC = 14;
   localparam int MOVE_FRAC = 16;
   localparam int SCALE_FRAC = 16;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOCAL, ST_READ, ST_MUL, ST_SUM, ST_OUT
   } state_type;

   // signed saturate of a wide value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
      if (v > 80'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -80'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // round half up then arithmetic shift right by n (n >= 1)
   function automatic logic signed [79:0] rshift(input logic signed [79:0] v,
                                                 input int n);
      logic signed [79:0] t;
      t = v + (80'sd1 <<< (n - 1));
      return t >>> n;
   endfunction
endpackage

[rtl/smp_local.sv]
// Local affine element builder: one element of [ s*R(q) | t ] per request.
// Depends on smp_pkg.
module smp_local #(
   parameter int FRAC_BITS = smp_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic signed [15:0] qx, qy, qz, qw,
   input  logic signed [31:0] mv,
   input  logic        [23:0] scale,
   input  logic        [1:0]  row,
   input  logic        [1:0]  col,
   output logic signed [31:0] elem_ff
);
   import smp_pkg::*;
   logic signed [35:0] rot_in, rot_ff;
   logic signed [31:0] mv_ff;
   logic        [1:0]  col_ff;
   logic signed [79:0] prod, scaled, mvx;
   logic signed [31:0] elem_in;
   logic signed [33:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
   localparam logic signed [35:0] ONE = 36'sd1 <<< (2 * QUAT_FRAC);

   always_comb begin
      xx = 34'(qx * qx); yy = 34'(qy * qy); zz = 34'(qz * qz);
      xy = 34'(qx * qy); xz = 34'(qx * qz); yz = 34'(qy * qz);
      xw = 34'(qx * qw); yw = 34'(qy * qw); zw = 34'(qz * qw);
      rot_in = '0;
      case ({row, col})
         4'h0: rot_in = ONE - 36'(2 * yy) - 36'(2 * zz);
         4'h1: rot_in = 36'(2 * xy) - 36'(2 * zw);
         4'h2: rot_in = 36'(2 * xz) + 36'(2 * yw);
         4'h4: rot_in = 36'(2 * xy) + 36'(2 * zw);
         4'h5: rot_in = ONE - 36'(2 * xx) - 36'(2 * zz);
         4'h6: rot_in = 36'(2 * yz) - 36'(2 * xw);
         4'h8: rot_in = 36'(2 * xz) - 36'(2 * yw);
         4'h9: rot_in = 36'(2 * yz) + 36'(2 * xw);
         4'hA: rot_in = ONE - 36'(2 * xx) - 36'(2 * yy);
         default: rot_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in;
      mv_ff  <= mv;
      col_ff <= col;
   end

   always_comb begin
      prod = 80'(rot_ff) * $signed({1'b0, scale});
      scaled = rshift(prod, 2 * QUAT_FRAC + SCALE_FRAC - FRAC_BITS);
      if (FRAC_BITS > MOVE_FRAC) mvx = 80'(mv_ff) <<< (FRAC_BITS - MOVE_FRAC);
      else if (FRAC_BITS < MOVE_FRAC) mvx = rshift(80'(mv_ff), MOVE_FRAC - FRAC_BITS);
      else mvx = 80'(mv_ff);
      elem_in = (col_ff == 2'd3) ? sat32(mvx) : sat32(scaled);
   end

   always_ff @(posedge clock) elem_ff <= elem_in;
endmodule

[rtl/skeleton_matrix_palette_unit.sv]
// Skeleton matrix palette top level: sequencer, local element unit and world matrix store.
// Depends on smp_pkg and smp_local.
//
// Usage: one request per skeleton node on req_*, in node order. Each request
// yields three response rows on rsp_* (rows 0, 1, 2; rsp_row_last on row 2).
// A request is taken only in the idle cycle after the previous node's rows are out.
// Per node the sequencer builds the 12 local elements one per cycle through a
// two-stage multiply unit. For a child it then forms each of the 12 world
// elements from three products, each product passing through a read, a multiply
// and an accumulate state; each finished element is written back. Row 0 is
// output after the local sequence for a root or a bad parent, after the world
// sequence for a child; rows follow one per cycle while rsp_stall is low.
// Without stalls the local sequence and, for a child, the world sequence set
// the request rate.
// rsp_stall holds the current row; no further request is taken meanwhile.
// Reset clears the node counter and sequencer; the store needs no clearing,
// since a parent is always a node already written in the current pass.
module skeleton_matrix_palette_unit #(
   parameter int NODE_SLOTS = smp_pkg::NODE_SLOTS_DEF,
   parameter int FRAC_BITS  = smp_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_x, req_quat_y, req_quat_z, req_quat_w,
   input  logic signed [31:0] req_move_x, req_move_y, req_move_z,
   input  logic        [23:0] req_uniform_scale,
   input  logic        [7:0]  req_parent_index,
   input  logic               req_pose_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [7:0]  rsp_node_number,
   output logic        [1:0]  rsp_row_number,
   output logic signed [31:0] rsp_col0, rsp_col1, rsp_col2, rsp_col3,
   output logic               rsp_bad_parent,
   output logic               rsp_row_last
);
   import smp_pkg::*;
   localparam int NB = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
   localparam int AW = $clog2(NODE_SLOTS * 12);

   state_type state_ff, state_in;
   logic [NB-1:0] node_ff;
   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [31:0] mx_ff, my_ff, mz_ff;
   logic [23:0] sc_ff;
   logic [7:0] par_ff;
   logic end_ff, bad_ff, child_ff;
   logic [3:0] cnt_ff;       // element index 0..11 (row*4+col), 12 once local issue is done
   logic [1:0] k_ff;         // product index for world multiply
   logic [1:0] orow_ff;
   logic signed [31:0] loc_ff [12];
   logic signed [31:0] wm_ff [12];
   logic signed [31:0] pa_ff;      // parent element read data
   logic signed [79:0] acc_ff;
   logic signed [31:0] store [NODE_SLOTS*12];
   logic [AW-1:0] raddr, waddr;
   logic we;
   logic signed [31:0] wdata;
   logic signed [31:0] lelem;
   logic [1:0] lrow, lcol;
   logic [3:0] lcnt_ff;
   logic lpipe1_ff, lpipe2_ff;
   logic signed [79:0] pmul_ff;
   logic signed [31:0] store_t_ff;
   logic lpipe_done;
   logic signed [31:0] mv_sel;

   assign lrow = 2'(cnt_ff >> 2);
   assign lcol = cnt_ff[1:0];
   assign lpipe_done = (cnt_ff == 4'd12);

   // the translation column picks move by row, not column
   always_comb mv_sel = lrow == 2'd0 ? mx_ff : lrow == 2'd1 ? my_ff : mz_ff;

   smp_local #(.FRAC_BITS(FRAC_BITS)) u_local (
      .clock(clock), .qx(qx_ff), .qy(qy_ff), .qz(qz_ff), .qw(qw_ff),
      .mv(mv_sel),
      .scale(sc_ff), .row(lcol == 2'd3 ? 2'd3 : lrow), .col(lcol), .elem_ff(lelem)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_LOCAL;
         ST_LOCAL: if (lpipe2_ff && lcnt_ff == 4'd11)
                      state_in = child_ff ? ST_READ : ST_OUT;
         ST_READ:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_SUM;
         ST_SUM:   if (k_ff == 2'd2 && cnt_ff == 4'd11) state_in = ST_OUT;
                   else state_in = ST_READ;
         ST_OUT:   if (!rsp_stall && orow_ff == 2'd2) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // parent element (row i, col k) for world element (i, c)
   always_comb begin
      raddr = AW'(par_ff[NB-1:0]) * AW'(12) + AW'({2'b0, lrow} * 4 + 4'(k_ff));
      if (!child_ff || state_ff != ST_SUM) begin
         we = 1'b0;
      end else begin
         we = (k_ff == 2'd2);
      end
   end

   logic signed [79:0] term, sum;
   always_comb begin
      term = rshift(80'(pa_ff) * 80'(loc_ff[{k_ff, lcol}]), FRAC_BITS);
      sum = acc_ff + pmul_ff;
      if (k_ff == 2'd2 && lcol == 2'd3) sum = sum + 80'(store_t_ff);
      wdata = sat32(sum);
      waddr = AW'(node_ff) * AW'(12) + AW'(cnt_ff);
   end

   always_ff @(posedge clock) begin
      pa_ff <= store[raddr];
      store_t_ff <= store[AW'(par_ff[NB-1:0]) * AW'(12) + AW'({2'b0, lrow} * 4 + 4'd3)];
      if (we) store[waddr] <= wdata;
      if (state_ff == ST_LOCAL && lpipe2_ff && !child_ff) begin
         store[AW'(node_ff) * AW'(12) + AW'(lcnt_ff)] <= lelem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         node_ff <= '0;
         lpipe1_ff <= 1'b0;
         lpipe2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lpipe1_ff <= (state_ff == ST_LOCAL) && cnt_ff != 4'd12 && !lpipe_done;
         lpipe2_ff <= lpipe1_ff;
         if (state_ff == ST_OUT && state_in == ST_IDLE) begin
            if (end_ff || node_ff == NB'(NODE_SLOTS - 1)) node_ff <= '0;
            else node_ff <= node_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            qx_ff <= req_quat_x; qy_ff <= req_quat_y;
            qz_ff <= req_quat_z; qw_ff <= req_quat_w;
            mx_ff <= req_move_x; my_ff <= req_move_y; mz_ff <= req_move_z;
            sc_ff <= req_uniform_scale; par_ff <= req_parent_index;
            end_ff <= req_pose_end;
            bad_ff <= req_parent_index != ROOT_MARK && 32'(req_parent_index) >= 32'(node_ff);
            child_ff <= req_parent_index != ROOT_MARK && 32'(req_parent_index) < 32'(node_ff);
            cnt_ff <= '0; lcnt_ff <= '0; k_ff <= '0; orow_ff <= '0; acc_ff <= '0;
         end
         ST_LOCAL: begin
            if (!lpipe_done) cnt_ff <= cnt_ff + 4'd1;
            lcnt_ff <= 4'(cnt_ff - 4'd1);
            if (lpipe2_ff) begin
               loc_ff[lcnt_ff] <= lelem;
               wm_ff[lcnt_ff] <= lelem;
            end
            if (lpipe2_ff && lcnt_ff == 4'd11) cnt_ff <= '0;
         end
         ST_MUL: pmul_ff <= term;
         ST_SUM: begin
            if (k_ff == 2'd2) begin
               wm_ff[cnt_ff] <= wdata;
               acc_ff <= '0; k_ff <= '0;
               if (cnt_ff != 4'd11) cnt_ff <= cnt_ff + 4'd1;
            end else begin
               acc_ff <= sum; k_ff <= k_ff + 2'd1;
            end
         end
         ST_OUT: if (!rsp_stall) orow_ff <= orow_ff + 2'd1;
         default: ;
      endcase
   end

   assign rsp_node_number = 8'(node_ff);
   assign rsp_row_number = orow_ff;
   assign rsp_col0 = wm_ff[{orow_ff, 2'd0}];
   assign rsp_col1 = wm_ff[{orow_ff, 2'd1}];
   assign rsp_col2 = wm_ff[{orow_ff, 2'd2}];
   assign rsp_col3 = wm_ff[{orow_ff, 2'd3}];
   assign rsp_bad_parent = bad_ff;
   assign rsp_row_last = (orow_ff == 2'd2);

`ifndef NO_ASSERTIONS
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("response while accepting");
   a_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> orow_ff != 2'd3) else $error("row out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(orow_ff)) else $error("row dropped");
`endif
endmodule
